>>> hdl/thcm_pkg.sv
// Shared types, codes and the channel mapping table for the TDC hit monitor.
package thcm_pkg;

  localparam int unsigned ID_BINS  = 16;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = 2;
  localparam logic [10:0] FRAME_ID_RESET = 11'h201;

  localparam logic [2:0] REQ_DATA  = 3'd0;
  localparam logic [2:0] REQ_RD_CH = 3'd1;
  localparam logic [2:0] REQ_RD_PR = 3'd2;
  localparam logic [2:0] REQ_RD_ID = 3'd3;
  localparam logic [2:0] REQ_RD_EV = 3'd4;

  localparam logic [3:0] PID_HIT  = 4'h4;
  localparam logic [3:0] PID_HALF = 4'hc;
  localparam logic [3:0] PID_END  = 4'he;
  localparam logic [1:0] SUB_NONE = 2'd3;

  typedef enum logic [2:0] {
    K_WORD    = 3'd0,
    K_RD_CH   = 3'd1,
    K_RD_PAIR = 3'd2,
    K_RD_PID  = 3'd3,
    K_RD_EV   = 3'd4,
    K_RD_ERR  = 3'd5
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [3:0]       pid;
    logic             hit_valid;
    logic             end_evt;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
  } cmd_t;

  function automatic logic [4:0] chan_map(input logic [1:0] sub, input logic [2:0] sel);
    logic [4:0] r;
    r = 5'd0;
    case (sub)
      2'd0: begin
        case (sel)
          3'd0: r = 5'd2;  3'd1: r = 5'd16; 3'd2: r = 5'd9;  3'd3: r = 5'd14;
          3'd4: r = 5'd7;  3'd5: r = 5'd4;  3'd6: r = 5'd11; default: r = 5'd0;
        endcase
      end
      2'd1: begin
        case (sel)
          3'd0: r = 5'd12; 3'd1: r = 5'd23; 3'd2: r = 5'd3;  3'd3: r = 5'd10;
          3'd4: r = 5'd21; 3'd5: r = 5'd19; 3'd6: r = 5'd5;  default: r = 5'd1;
        endcase
      end
      2'd2: begin
        case (sel)
          3'd0: r = 5'd18; 3'd1: r = 5'd20; 3'd2: r = 5'd13; 3'd3: r = 5'd15;
          3'd4: r = 5'd8;  3'd5: r = 5'd22; 3'd6: r = 5'd17; default: r = 5'd6;
        endcase
      end
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/thcm_front.sv
// Front end: frame filter, request classification, channel mapping, half selector.
module thcm_front import thcm_pkg::*; #(
  parameter int unsigned CHANNELS = 192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [10:0] frame_id,
  input  logic [31:0] data_word,
  input  logic [7:0]  index_a,
  input  logic [7:0]  index_b,
  output logic        push,
  output cmd_t        cmd,
  input  logic        full
);

  localparam logic [9:0] NCH  = 10'(CHANNELS);
  localparam logic [9:0] HALF = 10'(CHANNELS / 2);

  logic [10:0] match_frame_id;
  logic        half_select;
  logic        accept;
  logic        keep;
  logic [3:0]  pid;
  logic [3:0]  tdc;
  logic [9:0]  ch;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign pid      = data_word[31:28];
  assign tdc      = data_word[27:24];
  assign ch       = 10'(tdc[3:2]) * 10'd24 + 10'(chan_map(tdc[1:0], data_word[23:21]))
                  + (half_select ? HALF : 10'd0);

  always_comb begin
    cmd           = '0;
    cmd.kind      = K_WORD;
    cmd.pid       = pid;
    cmd.idx_a     = index_a;
    cmd.idx_b     = index_b;
    keep          = 1'b1;
    case (req_type)
      REQ_DATA: begin
        keep          = (frame_id == match_frame_id);
        cmd.hit_valid = (pid == PID_HIT) && (tdc[1:0] != SUB_NONE) && (ch < NCH);
        cmd.end_evt   = (pid == PID_END) && (tdc == 4'd0);
        cmd.idx_a     = ch[7:0];
      end
      REQ_RD_CH: cmd.kind = (10'(index_a) < NCH) ? K_RD_CH : K_RD_ERR;
      REQ_RD_PR: cmd.kind = (10'(index_a) < NCH && 10'(index_b) < NCH) ? K_RD_PAIR : K_RD_ERR;
      REQ_RD_ID: cmd.kind = (index_a < 8'(ID_BINS)) ? K_RD_PID : K_RD_ERR;
      REQ_RD_EV: cmd.kind = K_RD_EV;
      default:   keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_frame_id <= FRAME_ID_RESET;
      half_select    <= 1'b1;
    end else begin
      if (cfg_write) match_frame_id <= cfg_data;
      if (push && cmd.kind == K_WORD && pid == PID_HALF) half_select <= data_word[0];
    end
  end

endmodule

>>> hdl/thcm_queue.sv
// Short command queue between front end and counter engine.
module thcm_queue import thcm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   cnt;

  assign full  = (cnt == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt <= (QPTR_W+1)'(QDEPTH)) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_push_notfull: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

endmodule

>>> hdl/thcm_back.sv
// Counter engine: histograms, end-of-event pair walk, read-out register.
module thcm_back import thcm_pkg::*; #(
  parameter int unsigned CHANNELS   = 192,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic        index_error
);

  localparam int unsigned CIW   = $clog2(CHANNELS);
  localparam int unsigned PAW   = $clog2(CHANNELS * CHANNELS);
  localparam int unsigned PDEP  = CHANNELS * CHANNELS;
  localparam logic [CIW-1:0] CH_LAST  = CIW'(CHANNELS - 1);
  localparam logic [PAW-1:0] CLR_LAST = PAW'(PDEP - 1);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_WALK_A  = 8'b0000_0100,
    S_CH_WR   = 8'b0000_1000,
    S_WALK_B  = 8'b0001_0000,
    S_PAIR_WR = 8'b0010_0000,
    S_RD_ADDR = 8'b0100_0000,
    S_RD_OUT  = 8'b1000_0000
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  state_t                state, state_next;
  logic [PAW-1:0]        clr;
  logic [CIW-1:0]        a, b;
  logic [PAW-1:0]        base;
  logic [PAW-1:0]        rd_addr;
  logic                  rd_pair;
  logic [CHANNELS-1:0]   hit;
  logic [COUNT_BITS-1:0] pid_cnt [ID_BINS];
  logic [COUNT_BITS-1:0] event_count;

  logic [COUNT_BITS-1:0] ch_mem   [CHANNELS];
  logic [COUNT_BITS-1:0] pair_mem [PDEP];
  logic [COUNT_BITS-1:0] ch_rdata, pair_rdata;
  logic                  ch_re, ch_we, pair_re, pair_we;
  logic [CIW-1:0]        ch_addr;
  logic [PAW-1:0]        pair_addr;
  logic [COUNT_BITS-1:0] ch_wdata, pair_wdata;

  logic                  out_free, load;
  logic [COUNT_BITS-1:0] load_val;
  logic                  load_err;
  logic                  walk_done;
  logic                  next_a;

  assign out_free = !out_valid || !out_stall;
  assign pop = (state == S_IDLE) && !empty && (cmd.kind == K_WORD || out_free);

  always_comb begin
    state_next = state;
    ch_re = 1'b0; ch_we = 1'b0; pair_re = 1'b0; pair_we = 1'b0;
    ch_addr = a;
    pair_addr = base + PAW'(b);
    ch_wdata = sat_inc(ch_rdata);
    pair_wdata = sat_inc(pair_rdata);
    load = 1'b0; load_val = '0; load_err = 1'b0;
    walk_done = 1'b0; next_a = 1'b0;
    case (state)
      S_CLEAR: begin
        ch_addr    = clr[CIW-1:0];
        pair_addr  = clr;
        ch_wdata   = '0;
        pair_wdata = '0;
        ch_we      = (clr < PAW'(CHANNELS));
        pair_we    = 1'b1;
        if (clr == CLR_LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        ch_addr = cmd.idx_a[CIW-1:0];
        if (pop) begin
          case (cmd.kind)
            K_WORD:    if (cmd.end_evt) state_next = S_WALK_A;
            K_RD_CH:   begin ch_re = 1'b1; state_next = S_RD_OUT; end
            K_RD_PAIR: state_next = S_RD_ADDR;
            K_RD_PID:  begin load = 1'b1; load_val = pid_cnt[cmd.idx_a[3:0]]; end
            K_RD_EV:   begin load = 1'b1; load_val = event_count; end
            K_RD_ERR:  begin load = 1'b1; load_err = 1'b1; end
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_WALK_A: begin
        if (hit[a]) begin
          ch_re = 1'b1;
          state_next = S_CH_WR;
        end else if (a == CH_LAST) begin
          walk_done = 1'b1;
          state_next = S_IDLE;
        end else begin
          next_a = 1'b1;
        end
      end
      S_CH_WR: begin
        ch_we = 1'b1;
        state_next = S_WALK_B;
      end
      S_WALK_B, S_PAIR_WR: begin
        if (state == S_WALK_B && hit[b]) begin
          pair_re = 1'b1;
          state_next = S_PAIR_WR;
        end else begin
          pair_we = (state == S_PAIR_WR);
          if (b != CH_LAST) begin
            state_next = S_WALK_B;
          end else if (a == CH_LAST) begin
            walk_done = 1'b1;
            state_next = S_IDLE;
          end else begin
            next_a = 1'b1;
            state_next = S_WALK_A;
          end
        end
      end
      S_RD_ADDR: begin
        pair_addr = rd_addr;
        pair_re = 1'b1;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (out_free) begin
          load = 1'b1;
          load_val = rd_pair ? pair_rdata : ch_rdata;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ch_we) ch_mem[ch_addr] <= ch_wdata;
    if (ch_re) ch_rdata <= ch_mem[ch_addr];
  end

  always_ff @(posedge clk) begin
    if (pair_we) pair_mem[pair_addr] <= pair_wdata;
    if (pair_re) pair_rdata <= pair_mem[pair_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr         <= '0;
      a           <= '0;
      b           <= '0;
      base        <= '0;
      hit         <= '0;
      event_count <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < ID_BINS; i++) pid_cnt[i] <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (load) out_valid <= 1'b1;
      if (pop && cmd.kind == K_WORD) begin
        pid_cnt[cmd.pid] <= sat_inc(pid_cnt[cmd.pid]);
        if (cmd.hit_valid) hit[cmd.idx_a[CIW-1:0]] <= 1'b1;
        if (cmd.end_evt) begin
          event_count <= sat_inc(event_count);
          a    <= '0;
          base <= '0;
        end
      end
      if (state == S_CH_WR) b <= '0;
      if ((state == S_WALK_B && !hit[b]) || state == S_PAIR_WR) b <= b + 1'b1;
      if (next_a) begin
        a    <= a + 1'b1;
        base <= base + PAW'(CHANNELS);
      end
      if (walk_done) hit <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.kind == K_RD_PAIR)
      rd_addr <= PAW'(PAW'(cmd.idx_a[CIW-1:0]) * PAW'(CHANNELS)) + PAW'(cmd.idx_b[CIW-1:0]);
    if (pop) rd_pair <= (cmd.kind == K_RD_PAIR);
    if (load) begin
      read_value  <= 32'(load_val);
      index_error <= load_err;
    end
  end

  a_clear_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !pop) else $error("command taken during clear pass");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free) else $error("result overwrites pending output");
  a_walk_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_A || state == S_WALK_B || state == S_PAIR_WR) ##1 state == S_IDLE
    |-> hit == '0) else $error("hit flags left set after event");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    load && load_err |-> load_val == '0) else $error("error result carries a value");

endmodule

>>> hdl/tdc_hit_coincidence_monitor.sv
// Top level of the TDC hit and coincidence monitor.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  config   | cfg_write             | cfg_data (match_frame_id)
//  request  | in_valid / in_stall   | req_type, frame_id, data_word, index_a, b
//  result   | out_valid / out_stall | read_value, index_error
//
// After reset the counter memories are cleared, one pair entry per cycle,
// before the first command runs. An ending event walks the hit flags channel by
// channel; for each hit channel it increments the channel counter, then walks
// all partner channels and increments the pair counter of each hit partner via
// the single read-modify-write port of the pair memory.
// A four-entry queue lets requests keep arriving while the walk or a stalled
// output holds the counter engine.
module tdc_hit_coincidence_monitor import thcm_pkg::*; #(
  parameter int unsigned CHANNELS   = 192,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [10:0] frame_id,
  input  logic [31:0] data_word,
  input  logic [7:0]  index_a,
  input  logic [7:0]  index_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_value,
  output logic        index_error
);

  logic push, full, pop, empty;
  cmd_t push_cmd, head;

  thcm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst, .cfg_write, .cfg_data, .in_valid, .in_stall,
    .req_type, .frame_id, .data_word, .index_a, .index_b,
    .push(push), .cmd(push_cmd), .full(full)
  );

  thcm_queue u_queue (
    .clk, .rst, .push(push), .push_cmd(push_cmd), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  thcm_back #(.CHANNELS(CHANNELS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .cmd(head), .empty(empty), .pop(pop),
    .out_valid, .out_stall, .read_value, .index_error
  );

endmodule

>>> dv/tdc_hit_coincidence_monitor_tb.sv
// Self-checking testbench for the TDC hit and coincidence monitor.
module tdc_hit_coincidence_monitor_tb;
  import thcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NCH = 192;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [2:0] REQ_SPARE_MID = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } readback_t;

  class coincidence_scoreboard;
    logic [10:0] match_id;
    bit          hit[NCH];
    logic [31:0] chan_cnt[NCH];
    logic [31:0] pair_cnt[NCH*NCH];
    logic [31:0] pid_cnt[ID_BINS];
    logic [31:0] evt_cnt;
    bit          half;
    int          recent[4];
    readback_t   pending[$];
    int          errors;
    int          checked;
    int          events;

    function new();
      match_id = FRAME_ID_RESET;
      foreach (hit[i]) begin
        hit[i] = 0;
        chan_cnt[i] = '0;
      end
      foreach (pair_cnt[i]) pair_cnt[i] = '0;
      foreach (pid_cnt[i]) pid_cnt[i] = '0;
      foreach (recent[i]) recent[i] = i;
      evt_cnt = '0;
      half = 1;
      errors = 0;
      checked = 0;
      events = 0;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
    endfunction

    function automatic int lookup(logic [1:0] sub, logic [2:0] sel);
      int tbl [3][8] = '{'{2, 16, 9, 14, 7, 4, 11, 0},
                         '{12, 23, 3, 10, 21, 19, 5, 1},
                         '{18, 20, 13, 15, 8, 22, 17, 6}};
      return tbl[sub][sel];
    endfunction

    function void close_event();
      events++;
      evt_cnt = bump(evt_cnt);
      for (int a = 0; a < NCH; a++) begin
        if (hit[a]) begin
          chan_cnt[a] = bump(chan_cnt[a]);
          for (int b = 0; b < NCH; b++)
            if (hit[b]) pair_cnt[a*NCH+b] = bump(pair_cnt[a*NCH+b]);
        end
      end
      foreach (hit[i]) hit[i] = 0;
    endfunction

    function void decode(logic [31:0] w);
      logic [3:0] pid;
      logic [3:0] tdc;
      int ch;
      pid = w[31:28];
      tdc = w[27:24];
      pid_cnt[pid] = bump(pid_cnt[pid]);
      if (pid == PID_HIT) begin
        if (tdc[1:0] != SUB_NONE) begin
          ch = 24 * tdc[3:2] + lookup(tdc[1:0], w[23:21]) + (NCH / 2) * half;
          if (ch < NCH) begin
            hit[ch] = 1;
            recent[$urandom_range(0, 3)] = ch;
          end
        end
      end else if (pid == PID_HALF) begin
        half = w[0];
      end else if (pid == PID_END && tdc == 4'd0) begin
        close_event();
      end
    endfunction

    function void note_request(logic [2:0] req, logic [10:0] fid, logic [31:0] w,
                               logic [7:0] ia, logic [7:0] ib);
      readback_t r;
      r = '0;
      case (req)
        REQ_DATA: begin
          if (fid == match_id) decode(w);
          return;
        end
        REQ_RD_CH: if (ia < NCH) r.value = chan_cnt[ia]; else r.err = 1;
        REQ_RD_PR: if (ia < NCH && ib < NCH) r.value = pair_cnt[ia*NCH+ib]; else r.err = 1;
        REQ_RD_ID: if (ia < ID_BINS) r.value = pid_cnt[ia]; else r.err = 1;
        REQ_RD_EV: r.value = evt_cnt;
        default: return;
      endcase
      pending.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [31:0] value, logic err);
      readback_t e;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%h err=%b", value, err));
        return;
      end
      e = pending.pop_front();
      if (value !== e.value)
        report($sformatf("read_value got %h want %h", value, e.value));
      if (err !== e.err)
        report($sformatf("index_error got %b want %b", err, e.err));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [10:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [10:0] frame_id;
  logic [31:0] data_word;
  logic [7:0]  index_a;
  logic [7:0]  index_b;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_value;
  logic        index_error;

  coincidence_scoreboard sb;
  int  cycles;
  int  hold_cycles;
  bit  quiet;
  int  sent;

  tdc_hit_coincidence_monitor uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .frame_id(frame_id), .data_word(data_word), .index_a(index_a),
    .index_b(index_b), .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .index_error(index_error)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // transfer monitors; reads in the active region see pre-edge values
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_request(req_type, frame_id, data_word, index_a, index_b);
    if (!rst && out_valid && !out_stall)
      sb.check_result(read_value, index_error);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result-side backpressure
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 13);
      end
    end
  end

  // valid stays up after a transfer until the next send or an idle point drops it
  task automatic send(logic [2:0] req, logic [10:0] fid, logic [31:0] w,
                      logic [7:0] ia, logic [7:0] ib);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    req_type <= req;
    frame_id <= fid;
    data_word <= w;
    index_a <= ia;
    index_b <= ib;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic data(logic [31:0] w);
    send(REQ_DATA, sb.match_id, w, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // an event read queues behind any walk still in progress
  task automatic set_frame_id(logic [10:0] id);
    send(REQ_RD_EV, 11'($urandom), 32'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();
    repeat (20) @(negedge clk);
    cfg_write <= 1;
    cfg_data <= id;
    @(posedge clk);
    sb.match_id = id;
    @(negedge clk);
    cfg_write <= 0;
  endtask

  task automatic random_item();
    int r;
    logic [31:0] w;
    logic [7:0] ia, ib;
    logic [10:0] fid;
    r = $urandom_range(0, 99);
    w = $urandom;
    fid = ($urandom_range(0, 9) == 0) ? 11'($urandom) : sb.match_id;
    if (r < 45) begin
      w[31:28] = PID_HIT;
      send(REQ_DATA, fid, w, 8'($urandom), 8'($urandom));
    end else if (r < 50) begin
      w[31:28] = PID_HALF;
      send(REQ_DATA, fid, w, 8'($urandom), 8'($urandom));
    end else if (r < 58) begin
      w[31:28] = PID_END;
      if ($urandom_range(0, 99) < 85) w[27:24] = 4'd0;
      send(REQ_DATA, fid, w, 8'($urandom), 8'($urandom));
    end else if (r < 63) begin
      send(REQ_DATA, fid, w, 8'($urandom), 8'($urandom));
    end else if (r < 66) begin
      send(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 11'($urandom), w,
           8'($urandom), 8'($urandom));
    end else begin
      ia = ($urandom_range(0, 1)) ? 8'(sb.recent[$urandom_range(0, 3)])
                                  : 8'($urandom_range(0, NCH - 1));
      ib = ($urandom_range(0, 1)) ? 8'(sb.recent[$urandom_range(0, 3)])
                                  : 8'($urandom_range(0, NCH - 1));
      if ($urandom_range(0, 9) == 0) ia = 8'($urandom);
      if ($urandom_range(0, 9) == 0) ib = 8'($urandom);
      case ($urandom_range(0, 3))
        0: send(REQ_RD_CH, 11'($urandom), w, ia, ib);
        1: send(REQ_RD_PR, 11'($urandom), w, ia, ib);
        2: send(REQ_RD_ID, 11'($urandom), w, 8'($urandom_range(0, 20)), ib);
        default: send(REQ_RD_EV, 11'($urandom), w, ia, ib);
      endcase
    end
  endtask

  initial begin
    logic [10:0] ids[4];
    sb = new();
    cycles = 0;
    hold_cycles = 0;
    quiet = 0;
    sent = 0;
    rst = 1;
    cfg_write = 0;
    cfg_data = '0;
    in_valid = 0;
    req_type = REQ_DATA;
    frame_id = '0;
    data_word = '0;
    index_a = '0;
    index_b = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: mapping, unmapped slot, half select, mismatched frame, ranges
    data({PID_HIT, 4'h0, 3'd0, 21'h0});
    data({PID_HIT, 4'hf, 3'd7, 21'h1fffff});
    data({PID_HIT, 4'h3, 3'd2, 21'h0});
    send(REQ_DATA, ~sb.match_id, {PID_HIT, 4'h1, 3'd1, 21'h0}, 8'd0, 8'd0);
    data({PID_HALF, 28'h0});
    data({PID_HIT, 4'h9, 3'd5, 21'h0});
    data({PID_END, 4'h1, 24'h0});
    data({PID_END, 4'h0, 24'hffffff});
    send(REQ_RD_EV, 11'h7ff, 32'hffffffff, 8'hff, 8'hff);
    send(REQ_RD_CH, 11'd0, 32'd0, 8'd2 + 8'd96, 8'd0);
    send(REQ_RD_CH, 11'd0, 32'd0, 8'd191, 8'd0);
    send(REQ_RD_CH, 11'd0, 32'd0, 8'd192, 8'd0);
    send(REQ_RD_CH, 11'd0, 32'd0, 8'd255, 8'd0);
    send(REQ_RD_PR, 11'd0, 32'd0, 8'd98, 8'd98);
    send(REQ_RD_PR, 11'd0, 32'd0, 8'd98, 8'(sb.recent[0]));
    send(REQ_RD_PR, 11'd0, 32'd0, 8'd0, 8'd192);
    send(REQ_RD_PR, 11'd0, 32'd0, 8'd191, 8'd191);
    send(REQ_RD_ID, 11'd0, 32'd0, 8'd15, 8'd0);
    send(REQ_RD_ID, 11'd0, 32'd0, 8'd4, 8'd0);
    send(REQ_RD_ID, 11'd0, 32'd0, 8'd16, 8'd0);
    send(REQ_SPARE_LO, 11'd0, 32'd0, 8'd0, 8'd0);
    send(REQ_SPARE_MID, 11'd0, 32'd0, 8'd0, 8'd0);
    send(REQ_SPARE_HI, 11'd0, 32'd0, 8'd0, 8'd0);

    ids[0] = FRAME_ID_RESET;
    ids[1] = 11'd0;
    ids[2] = 11'h7ff;
    ids[3] = 11'($urandom);
    for (int p = 0; p < 4; p++) begin
      set_frame_id(ids[p]);
      quiet = (p == 3);
      for (int i = 0; i < 256; i++) begin
        if (p == 1 && i == 128) wait_drained();
        if (p == 2 && i == 64) hold_cycles = 3000;
        random_item();
      end
    end
    quiet = 0;
    wait_drained();
    repeat (3000) @(negedge clk);

    $display("Sent %0d requests over 4 frame-id settings; %0d events closed.",
             sent, sb.events);
    $display("Checked %0d read results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/thcm_pkg.sv
hdl/thcm_front.sv
hdl/thcm_queue.sv
hdl/thcm_back.sv
hdl/tdc_hit_coincidence_monitor.sv
dv/tdc_hit_coincidence_monitor_tb.sv
